// File: hw/rtl/mpv_pkg.sv
// mpv_pkg: shared types, constants and SHA-256 tables for the Merkle proof checker.
// No dependencies.
package mpv_pkg;

   localparam int INDEX_BITS_DEF = 32;
   localparam int LEAF_INDEX_W   = 32;

   typedef struct packed {
      logic [63:0] chunk_word0;
      logic [63:0] chunk_word1;
      logic [63:0] chunk_word2;
      logic [63:0] chunk_word3;
      logic        first_chunk;
      logic        last_chunk;
      logic [31:0] leaf_index;
   } req_type;

   typedef struct packed {
      logic       proof_valid;
      logic [1:0] verdict_code;
   } rsp_type;

   localparam logic [1:0] VERDICT_OK       = 2'd0;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd1;
   localparam logic [1:0] VERDICT_TWO      = 2'd2;

   // compressor control from the sequencer
   typedef struct packed {
      logic start;        // load chaining value and message block
      logic use_init;     // chaining value is the SHA-256 IV
   } cmp_ctl_type;

   function automatic logic [31:0] sha_k(input logic [5:0] i);
      logic [31:0] k;
      case (i)
         6'd0:  k = 32'h428a2f98; 6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf; 6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b; 6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4; 6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98; 6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
      endcase
      return k;
   endfunction

   localparam logic [255:0] SHA_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   localparam logic [511:0] PAD_512 = {32'h80000000, 448'd0, 32'd512};
   localparam logic [255:0] PAD_256 = {32'h80000000, 192'd0, 32'd256};

endpackage

// File: hw/rtl/mpv_sha_round.sv
// mpv_sha_round: SHA-256 compression, one round per cycle on a single round unit.
// Depends on mpv_pkg (round constants, IV, control struct).
module mpv_sha_round (
   input  logic                 clock,
   input  logic                 reset,
   input  mpv_pkg::cmp_ctl_type ctl,
   input  logic [255:0]         chain_in,   // used when use_init is low
   input  logic [511:0]         block_in,
   output logic                 done,       // one-cycle pulse, digest valid
   output logic [255:0]         digest
);

   logic [31:0]  w_ff [16];
   logic [31:0]  w_in [16];
   logic [255:0] st_ff, st_in;      // a..h
   logic [255:0] hv_ff, hv_in;      // chaining value
   logic [5:0]   rnd_ff, rnd_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1, w_new;
   logic [255:0] hv_start;

   always_comb begin
      {a, b, c, d, e, f, g, h} = st_ff;
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + mpv_pkg::sha_k(rnd_ff) + w_ff[0];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      s0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      hv_start = ctl.use_init ? mpv_pkg::SHA_IV : chain_in;

      w_in    = w_ff;
      st_in   = st_ff;
      hv_in   = hv_ff;
      rnd_in  = rnd_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         for (int i = 0; i < 16; i++) w_in[i] = block_in[511 - 32*i -: 32];
         st_in   = hv_start;
         hv_in   = hv_start;
         rnd_in  = 6'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // message schedule window slides by one word per round
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = w_new;
         st_in  = {t1 + t2, a, b, c, d + t1, e, f, g};
         rnd_in = rnd_ff + 6'd1;
         if (rnd_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      w_ff   <= w_in;
      st_ff  <= st_in;
      hv_ff  <= hv_in;
      rnd_ff <= rnd_in;
   end

   // feed-forward add, taken once the round pipeline has settled
   always_comb begin
      for (int i = 0; i < 8; i++)
         digest[255 - 32*i -: 32] = hv_ff[255 - 32*i -: 32] + st_ff[255 - 32*i -: 32];
   end
   assign done = done_ff;

endmodule

// File: hw/rtl/merkle_proof_verify.sv
// merkle_proof_verify: Merkle inclusion proof checker, double SHA-256.
// Depends on mpv_pkg and mpv_sha_round.
//
// Usage:
//   req_* carries one 32-byte chunk per word (four 64-bit lanes, byte 0 in
//   the top bits of lane 0) plus first/last marks and the leaf index. A
//   proof is a leaf word (first mark), zero or more sibling words, and a
//   root word (last mark). Only the root word yields a rsp_* word with the
//   verdict; leaf, sibling and stray words give none.
//   Leaf, root and ignored words need no compression. A sibling word runs
//   three SHA-256 compressions back to back on the one round unit, and
//   req_stall stays high until the last of them is done, so no new word
//   is taken while a sibling is being hashed.
//   A verdict sits in the rsp_ output register; req_stall stays high while
//   that word waits and rsp_stall is high. rsp_valid is never gated by stall.
//   Reset (synchronous, active high) clears the open-proof state and the
//   output valid flag; the hash, path and verdict registers keep what they hold.
module merkle_proof_verify #(
   parameter int INDEX_BITS = mpv_pkg::INDEX_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mpv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mpv_pkg::rsp_type rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_C1   = 4'b0010,   // first half of SHA(left||right)
      ST_C2   = 4'b0100,   // padding block
      ST_C3   = 4'b1000    // outer hash
   } state_type;

   state_type st_ff, st_in;
   logic [255:0]          hash_ff, hash_in;
   logic [255:0]          sib_ff, sib_in;
   logic [INDEX_BITS-1:0] path_ff, path_in;
   logic [1:0]            seen_ff, seen_in;
   logic                  ov_ff, ov_in;
   mpv_pkg::rsp_type      od_ff, od_in;
   logic                  kick_ff, kick_in;   // start pulse for next compression

   mpv_pkg::cmp_ctl_type ctl;
   logic [255:0] chain_sel, digest;
   logic [511:0] blk_sel;
   logic         cmp_done;
   logic [255:0] chunk;
   logic         accept;

   assign chunk = {req_data.chunk_word0, req_data.chunk_word1,
                   req_data.chunk_word2, req_data.chunk_word3};
   // room for a verdict is needed before taking any word
   assign req_stall = (st_ff != ST_IDLE) || (ov_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      ctl.start    = kick_ff;
      ctl.use_init = (st_ff != ST_C2);
      chain_sel    = digest;
      case (st_ff)
         ST_C1:   blk_sel = path_ff[0] ? {sib_ff, hash_ff} : {hash_ff, sib_ff};
         ST_C2:   blk_sel = mpv_pkg::PAD_512;
         ST_C3:   blk_sel = {digest, mpv_pkg::PAD_256};
         default: blk_sel = '0;
      endcase
   end

   mpv_sha_round u_round (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .chain_in (chain_sel),
      .block_in (blk_sel),
      .done     (cmp_done),
      .digest   (digest)
   );

   always_comb begin
      st_in   = st_ff;
      hash_in = hash_ff;
      sib_in  = sib_ff;
      path_in = path_ff;
      seen_in = seen_ff;
      ov_in   = ov_ff && rsp_stall;
      od_in   = od_ff;
      kick_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.first_chunk) begin
                  hash_in = chunk;
                  path_in = INDEX_BITS'(req_data.leaf_index &
                                        {mpv_pkg::LEAF_INDEX_W{1'b1}});
                  if (req_data.last_chunk) begin
                     // lone chunk: accepted without looking at it
                     seen_in = 2'd0;
                     ov_in   = 1'b1;
                     od_in   = '{proof_valid: 1'b1, verdict_code: mpv_pkg::VERDICT_OK};
                  end else begin
                     seen_in = 2'd1;
                  end
               end else if (seen_ff != 2'd0) begin
                  if (req_data.last_chunk) begin
                     seen_in = 2'd0;
                     ov_in   = 1'b1;
                     if (seen_ff == 2'd1)
                        od_in = '{proof_valid: 1'b0, verdict_code: mpv_pkg::VERDICT_TWO};
                     else if (hash_ff == chunk)
                        od_in = '{proof_valid: 1'b1, verdict_code: mpv_pkg::VERDICT_OK};
                     else
                        od_in = '{proof_valid: 1'b0,
                                  verdict_code: mpv_pkg::VERDICT_MISMATCH};
                  end else begin
                     sib_in  = chunk;
                     st_in   = ST_C1;
                     kick_in = 1'b1;
                  end
               end
            end
         end
         ST_C1: if (cmp_done) begin
            st_in   = ST_C2;
            kick_in = 1'b1;
         end
         ST_C2: if (cmp_done) begin
            st_in   = ST_C3;
            kick_in = 1'b1;
         end
         ST_C3: if (cmp_done) begin
            hash_in = digest;
            path_in = path_ff >> 1;
            if (seen_ff != 2'd3) seen_in = seen_ff + 2'd1;
            st_in   = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         seen_ff <= 2'd0;
         ov_ff   <= 1'b0;
         kick_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         seen_ff <= seen_in;
         ov_ff   <= ov_in;
         kick_ff <= kick_in;
      end
      hash_ff <= hash_in;
      sib_ff  <= sib_in;
      path_ff <= path_in;
      od_ff   <= od_in;
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = od_ff;

endmodule

// File: verif/merkle_proof_check.sv
// merkle_proof_check: watches the req_/rsp_ channels of merkle_proof_verify,
// predicts each verdict with its own double SHA-256 chain and compares.
// Depends on mpv_pkg for the word types and verdict codes.
module merkle_proof_check (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  mpv_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  mpv_pkg::rsp_type rsp_data,
   output int               fail_count,
   output int               verdicts_owed,
   output logic [255:0]     chain_hash
);

   localparam logic [2047:0] ROUND_K = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
   localparam logic [255:0] HASH_IV = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

   mpv_pkg::rsp_type verdict_q[$];
   logic [31:0]  path_q;
   logic [1:0]   depth_q;
   int           mism;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [255:0] compress(input logic [255:0] h, input logic [511:0] blk);
      logic [31:0] w[64];
      logic [31:0] a, b, c, d, e, f, g, hh, t1, t2, s0, s1;
      for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      {a, b, c, d, e, f, g, hh} = h;
      for (int i = 0; i < 64; i++) begin
         t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_K[2047-32*i -: 32] + w[i];
         t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         hh = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      return {h[255:224] + a, h[223:192] + b, h[191:160] + c, h[159:128] + d,
              h[127:96] + e, h[95:64] + f, h[63:32] + g, h[31:0] + hh};
   endfunction

   function automatic logic [255:0] pair_hash(input logic [255:0] lft, input logic [255:0] rgt);
      logic [255:0] h;
      h = compress(HASH_IV, {lft, rgt});
      h = compress(h, {32'h80000000, 448'd0, 32'd512});
      return compress(HASH_IV, {h, 32'h80000000, 192'd0, 32'd256});
   endfunction

   assign verdicts_owed = verdict_q.size();

   always @(posedge clock) begin
      logic [255:0] chunk;
      mpv_pkg::rsp_type v;
      mpv_pkg::rsp_type exp_v;
      if (reset) begin
         chain_hash <= '0;
         path_q     <= '0;
         depth_q    <= '0;
         fail_count <= 0;
         mism       = 0;
      end else begin
         if (req_valid && !req_stall) begin
            chunk = {req_data.chunk_word0, req_data.chunk_word1,
                     req_data.chunk_word2, req_data.chunk_word3};
            if (req_data.first_chunk) begin
               chain_hash <= chunk;
               path_q     <= req_data.leaf_index;
               if (req_data.last_chunk) begin
                  v.proof_valid = 1'b1; v.verdict_code = mpv_pkg::VERDICT_OK;
                  verdict_q.push_back(v);
                  depth_q <= 2'd0;
               end else depth_q <= 2'd1;
            end else if (depth_q != 2'd0) begin
               if (!req_data.last_chunk) begin
                  chain_hash <= path_q[0] ? pair_hash(chunk, chain_hash)
                                          : pair_hash(chain_hash, chunk);
                  path_q <= path_q >> 1;
                  if (depth_q != 2'd3) depth_q <= depth_q + 2'd1;
               end else begin
                  // two-chunk proof is refused before any compare
                  if (depth_q == 2'd1) v.verdict_code = mpv_pkg::VERDICT_TWO;
                  else if (chain_hash != chunk) v.verdict_code = mpv_pkg::VERDICT_MISMATCH;
                  else v.verdict_code = mpv_pkg::VERDICT_OK;
                  v.proof_valid = (v.verdict_code == mpv_pkg::VERDICT_OK);
                  verdict_q.push_back(v);
                  depth_q <= 2'd0;
               end
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               mism = mism + 1;
               if (mism <= 10) $display("unexpected verdict word %b", rsp_data);
            end else begin
               exp_v = verdict_q.pop_front();
               if (exp_v.proof_valid !== rsp_data.proof_valid ||
                   exp_v.verdict_code !== rsp_data.verdict_code) begin
                  mism = mism + 1;
                  if (mism <= 10)
                     $display("verdict: expected valid=%b code=%0d, got valid=%b code=%0d",
                              exp_v.proof_valid, exp_v.verdict_code,
                              rsp_data.proof_valid, rsp_data.verdict_code);
               end
            end
         end
         fail_count <= mism;
      end
   end
endmodule

// File: verif/tb_merkle_proof_verify.sv
// tb_merkle_proof_verify: stimulus and verdict for merkle_proof_verify.
// Depends on mpv_pkg, the block's RTL and merkle_proof_check.
module tb_merkle_proof_verify;

   localparam int WATCHDOG = 20000;   // idle cycles

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   mpv_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   mpv_pkg::rsp_type rsp_data;
   int           fail_count;
   int           verdicts_owed;
   logic [255:0] chain_hash;

   int           burst_left = 0;
   int           chunks_sent = 0;
   int           verdicts_taken = 0;
   int           idle_cycles = 0;
   int           hold_cnt = 0;
   bit           hold_done = 1'b0;
   int           stall_mode = 0;

   always #4 clock = ~clock;

   merkle_proof_verify u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   merkle_proof_check u_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .verdicts_owed(verdicts_owed), .chain_hash(chain_hash)
   );

   // receiver: stall pattern changes mode at random; one long hold-off
   // after 20 verdicts so the output register fills and req_ backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) verdicts_taken <= verdicts_taken + 1;
         if ($urandom_range(0, 255) == 0) stall_mode = $urandom_range(0, 2);
         if (!hold_done && verdicts_taken >= 20) begin
            hold_done = 1'b1;
            hold_cnt  = 3000;
         end
         if (hold_cnt > 0) begin
            hold_cnt  = hold_cnt - 1;
            rsp_stall <= 1'b1;
         end else case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // watchdog: cycles without any accepted word on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Mismatches found");
         $finish;
      end
   end

   function automatic logic [255:0] rand_chunk();
      logic [255:0] c;
      for (int i = 0; i < 8; i++) c[32*i +: 32] = $urandom;
      case ($urandom_range(0, 9))
         0: c = '0;
         1: c = '1;
         default: ;
      endcase
      return c;
   endfunction

   // one word on req_; the sender pauses between bursts of random length
   task automatic send(input logic [255:0] chunk, input bit first, input bit last,
                       input logic [31:0] idx);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
      end
      burst_left = burst_left - 1;
      req_valid <= 1'b1;
      req_data  <= '{chunk_word0: chunk[255:192], chunk_word1: chunk[191:128],
                     chunk_word2: chunk[127:64], chunk_word3: chunk[63:0],
                     first_chunk: first, last_chunk: last, leaf_index: idx};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      chunks_sent = chunks_sent + 1;
   endtask

   // root word; a good root waits with req_valid low before it takes the
   // predicted chain, so the predictor has caught up
   task automatic send_root(input bit good);
      logic [255:0] root;
      if (good) begin
         req_valid <= 1'b0;
         @(posedge clock);
         root = chain_hash;
      end else root = rand_chunk();
      send(root, 1'b0, 1'b1, $urandom);
   endtask

   task automatic proof(input int siblings, input bit good, input logic [31:0] idx);
      send(rand_chunk(), 1'b1, 1'b0, idx);
      for (int i = 0; i < siblings; i++) send(rand_chunk(), 1'b0, 1'b0, $urandom);
      send_root(good);
   endtask

   initial begin
      int pick;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send('1, 1'b1, 1'b1, '1);                 // lone chunk, all ones
      send('0, 1'b1, 1'b1, '0);                 // lone chunk, all zeros
      send(rand_chunk(), 1'b0, 1'b0, $urandom); // stray sibling, no open proof
      send(rand_chunk(), 1'b0, 1'b1, $urandom); // stray root, no open proof
      proof(0, 1'b1, 32'd5);                    // leaf then root: two chunks
      proof(1, 1'b1, 32'hffffffff);             // sibling on the left
      proof(1, 1'b1, 32'd0);                    // sibling on the right
      proof(2, 1'b0, 32'haaaaaaaa);             // root mismatch
      proof(3, 1'b1, 32'h55555555);             // chunk count saturates
      send(rand_chunk(), 1'b1, 1'b0, 32'd3);    // leaf dropped by a new leaf
      send(rand_chunk(), 1'b0, 1'b0, 32'd0);
      proof(1, 1'b1, 32'd2);
      send(rand_chunk(), 1'b1, 1'b0, 32'd1);    // open proof closed by lone chunk
      send(rand_chunk(), 1'b1, 1'b1, 32'd1);

      // random: mostly well-formed proofs, some noise and broken ones
      while (chunks_sent < 500) begin
         pick = $urandom_range(0, 9);
         if (pick < 6)
            proof($urandom_range(0, 5), $urandom_range(0, 3) != 0, $urandom);
         else if (pick == 6)
            send(rand_chunk(), 1'b1, 1'b1, $urandom);
         else if (pick == 7)
            send(rand_chunk(), 1'b0, $urandom_range(0, 1), $urandom);
         else begin
            send(rand_chunk(), 1'b1, 1'b0, $urandom);
            repeat ($urandom_range(0, 2)) send(rand_chunk(), 1'b0, 1'b0, $urandom);
         end
      end
      req_valid <= 1'b0;

      while (verdicts_owed != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end
endmodule
